// ----- hw/rtl/tlr_pkg.sv -----
// Shared types and constants of the thick line rasterizer.
// No dependencies; imported by the core, the top level and the checker.
package tlr_pkg;

  // Fixed field widths of the stream and register interfaces.
  localparam int RADIUS_BITS      = 8;
  localparam int COLOR_BITS       = 32;
  localparam int PIXEL_COORD_BITS = 12;
  localparam int CFG_SIZE_BITS    = 13;
  localparam int RSQ_BITS         = 2 * RADIUS_BITS;
  localparam int OFFSET_BITS      = RADIUS_BITS + 1;
  localparam int OUT_COORD_MAX    = 4095;
  localparam int APB_DATA_BITS    = 32;
  localparam int APB_ADDR_BITS    = 3;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Input command codes carried in tuser.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } tlr_cmd_e;

  // One result of a tick transaction.
  typedef struct packed {
    logic                        valid;
    logic [PIXEL_COORD_BITS-1:0] x;
    logic [PIXEL_COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]       color;
    logic                        done;
  } tlr_result_t;

endpackage

// ----- hw/rtl/tlr_core.sv -----
// Line walk state and brush scan of the thick line rasterizer.
// Depends on tlr_pkg; the top level feeds it from its input register.
module tlr_core import tlr_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           tick_i,
  input  logic signed [COORD_BITS-1:0]   xa_i,
  input  logic signed [COORD_BITS-1:0]   ya_i,
  input  logic signed [COORD_BITS-1:0]   xb_i,
  input  logic signed [COORD_BITS-1:0]   yb_i,
  input  logic signed [COORD_BITS:0]     dx_i,
  input  logic signed [COORD_BITS:0]     dy_i,
  input  logic        [COORD_BITS-1:0]   adx_i,
  input  logic        [COORD_BITS-1:0]   ady_i,
  input  logic        [RADIUS_BITS-1:0]  radius_i,
  input  logic        [RSQ_BITS-1:0]     rsq_i,
  input  logic        [COLOR_BITS-1:0]   color_i,
  input  logic [PIXEL_COORD_BITS-1:0]    col_top_i,
  input  logic [PIXEL_COORD_BITS-1:0]    row_top_i,
  output tlr_result_t                    result_o
);

  localparam int EW = COORD_BITS + 3;
  localparam int SW = ((COORD_BITS > OFFSET_BITS) ? COORD_BITS : OFFSET_BITS) + 1;
  localparam int CW = (SW > PIXEL_COORD_BITS) ? SW : PIXEL_COORD_BITS;
  localparam int SQW = RSQ_BITS + 2;

  // Clamp a signed pixel coordinate into 0..top.
  function automatic logic [PIXEL_COORD_BITS-1:0] clamp_coord(
    input logic signed [SW-1:0]         v,
    input logic [PIXEL_COORD_BITS-1:0]  top
  );
    logic [CW-1:0] vu;
    logic [CW-1:0] tu;
    vu = CW'($unsigned(v));
    tu = CW'(top);
    if (v < 0) begin
      return '0;
    end else if (vu > tu) begin
      return top;
    end else begin
      return vu[PIXEL_COORD_BITS-1:0];
    end
  endfunction

  logic                          busy_q, busy_d;
  logic                          major_x_q, major_x_d;
  logic signed [COORD_BITS-1:0]  cmaj_q, cmaj_d;
  logic signed [COORD_BITS-1:0]  cmin_q, cmin_d;
  logic signed [COORD_BITS-1:0]  limit_q, limit_d;
  logic                          minor_neg_q, minor_neg_d;
  logic signed [EW-1:0]          err_q, err_d;
  logic        [COORD_BITS-1:0]  dmaj_q, dmaj_d;
  logic        [COORD_BITS-1:0]  dmin_q, dmin_d;
  logic signed [OFFSET_BITS-1:0] col_q, col_d;
  logic signed [OFFSET_BITS-1:0] row_q, row_d;
  logic        [RSQ_BITS-1:0]    col_sq_q, col_sq_d;
  logic        [RSQ_BITS-1:0]    row_sq_q, row_sq_d;
  logic        [RSQ_BITS-1:0]    rsq_q, rsq_d;
  logic        [RADIUS_BITS-1:0] radius_q, radius_d;
  logic        [COLOR_BITS-1:0]  color_q, color_d;

  // Setup of a new line: pick the major axis and order the endpoints.
  logic                          s_major_x;
  logic signed [COORD_BITS:0]    s_maj_d;
  logic signed [COORD_BITS:0]    s_min_d;
  logic                          s_swap;
  logic        [COORD_BITS-1:0]  s_maj_abs;
  logic        [COORD_BITS-1:0]  s_min_abs;
  logic signed [COORD_BITS-1:0]  s_ma, s_mi, s_mb, s_nb;
  logic                          s_min_neg;
  logic signed [EW-1:0]          s_err;

  always_comb begin
    s_major_x = ady_i < adx_i;
    s_maj_d   = s_major_x ? dx_i : dy_i;
    s_min_d   = s_major_x ? dy_i : dx_i;
    s_maj_abs = s_major_x ? adx_i : ady_i;
    s_min_abs = s_major_x ? ady_i : adx_i;
    s_ma      = s_major_x ? xa_i : ya_i;
    s_mi      = s_major_x ? ya_i : xa_i;
    s_mb      = s_major_x ? xb_i : yb_i;
    s_nb      = s_major_x ? yb_i : xb_i;
    s_swap    = s_maj_d[COORD_BITS];
    // After a swap the minor delta changes sign; a zero delta stays positive.
    s_min_neg = s_swap ? (!s_min_d[COORD_BITS] && (s_min_d != '0)) : s_min_d[COORD_BITS];
    s_err     = $signed({2'b00, s_min_abs, 1'b0}) - $signed({3'b000, s_maj_abs});
  end

  // Brush scan and walk step of one tick.
  logic signed [OFFSET_BITS-1:0] r_s;
  logic                          col_last, row_last, at_end, in_brush;
  logic signed [COORD_BITS-1:0]  cx, cy;
  logic signed [SW-1:0]          px_s, py_s;
  logic signed [SQW-1:0]         col_sq_inc, row_sq_inc;
  logic signed [EW-1:0]          err_step;

  always_comb begin
    r_s        = $signed({1'b0, radius_q});
    col_last   = col_q >= r_s;
    row_last   = row_q >= r_s;
    at_end     = cmaj_q >= limit_q;
    in_brush   = ({1'b0, col_sq_q} + {1'b0, row_sq_q}) < {1'b0, rsq_q};
    cx         = major_x_q ? cmaj_q : cmin_q;
    cy         = major_x_q ? cmin_q : cmaj_q;
    px_s       = SW'(cx) + SW'(col_q);
    py_s       = SW'(cy) + SW'(row_q);
    // (o+1)^2 = o^2 + 2o + 1
    col_sq_inc = $signed({2'b00, col_sq_q}) + SQW'($signed({col_q, 1'b0})) + SQW'(1);
    row_sq_inc = $signed({2'b00, row_sq_q}) + SQW'($signed({row_q, 1'b0})) + SQW'(1);
    err_step   = (!err_q[EW-1] && (err_q != '0))
               ? EW'($signed({2'b00, dmin_q, 1'b0})) - EW'($signed({2'b00, dmaj_q, 1'b0}))
               : EW'($signed({2'b00, dmin_q, 1'b0}));
  end

  // Next state.
  always_comb begin
    busy_d      = busy_q;
    major_x_d   = major_x_q;
    cmaj_d      = cmaj_q;
    cmin_d      = cmin_q;
    limit_d     = limit_q;
    minor_neg_d = minor_neg_q;
    err_d       = err_q;
    dmaj_d      = dmaj_q;
    dmin_d      = dmin_q;
    col_d       = col_q;
    row_d       = row_q;
    col_sq_d    = col_sq_q;
    row_sq_d    = row_sq_q;
    rsq_d       = rsq_q;
    radius_d    = radius_q;
    color_d     = color_q;
    if (start_i) begin
      busy_d      = 1'b1;
      major_x_d   = s_major_x;
      cmaj_d      = s_swap ? s_mb : s_ma;
      cmin_d      = s_swap ? s_nb : s_mi;
      limit_d     = s_swap ? s_ma : s_mb;
      minor_neg_d = s_min_neg;
      err_d       = s_err;
      dmaj_d      = s_maj_abs;
      dmin_d      = s_min_abs;
      radius_d    = radius_i;
      rsq_d       = rsq_i;
      color_d     = color_i;
      col_d       = -$signed({1'b0, radius_i});
      row_d       = -$signed({1'b0, radius_i});
      col_sq_d    = rsq_i;
      row_sq_d    = rsq_i;
    end else if (tick_i && busy_q) begin
      if (!col_last) begin
        col_d    = col_q + OFFSET_BITS'(1);
        col_sq_d = col_sq_inc[RSQ_BITS-1:0];
      end else begin
        col_d    = -r_s;
        col_sq_d = rsq_q;
        if (!row_last) begin
          row_d    = row_q + OFFSET_BITS'(1);
          row_sq_d = row_sq_inc[RSQ_BITS-1:0];
        end else begin
          row_d    = -r_s;
          row_sq_d = rsq_q;
          if (at_end) begin
            busy_d = 1'b0;
          end else begin
            if (!err_q[EW-1] && (err_q != '0)) begin
              cmin_d = minor_neg_q ? cmin_q - COORD_BITS'(1) : cmin_q + COORD_BITS'(1);
            end
            err_d  = err_q + err_step;
            cmaj_d = cmaj_q + COORD_BITS'(1);
          end
        end
      end
    end
  end

  // Result of the current tick.
  always_comb begin
    result_o = '0;
    if (!busy_q) begin
      result_o.done = 1'b1;
    end else begin
      result_o.done = col_last && row_last && at_end;
      if (in_brush) begin
        result_o.valid = 1'b1;
        result_o.x     = clamp_coord(px_s, col_top_i);
        result_o.y     = clamp_coord(py_s, row_top_i);
        result_o.color = color_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      major_x_q   <= 1'b0;
      cmaj_q      <= '0;
      cmin_q      <= '0;
      limit_q     <= '0;
      minor_neg_q <= 1'b0;
      err_q       <= '0;
      dmaj_q      <= '0;
      dmin_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      col_sq_q    <= '0;
      row_sq_q    <= '0;
      rsq_q       <= '0;
      radius_q    <= '0;
      color_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      major_x_q   <= major_x_d;
      cmaj_q      <= cmaj_d;
      cmin_q      <= cmin_d;
      limit_q     <= limit_d;
      minor_neg_q <= minor_neg_d;
      err_q       <= err_d;
      dmaj_q      <= dmaj_d;
      dmin_q      <= dmin_d;
      col_q       <= col_d;
      row_q       <= row_d;
      col_sq_q    <= col_sq_d;
      row_sq_q    <= row_sq_d;
      rsq_q       <= rsq_d;
      radius_q    <= radius_d;
      color_q     <= color_d;
    end
  end

endmodule

// ----- hw/rtl/thick_line_rasterizer.sv -----
// Top level of the thick line rasterizer: stream ports, APB registers,
// input and output registers. Depends on tlr_pkg and tlr_core.
//
//   channel  | direction | handshake              | contents
//   s_axis   | in        | tvalid/tready          | start or tick command
//   m_axis   | out       | tvalid/tready          | one pixel result per tick
//   apb      | in        | psel/penable, pready=1 | image_width, image_height
//
// Every tick yields one result; one transaction is taken per cycle when the
// output is drained. A tick passes through the input register, then the walk
// and brush logic into the output register. A line takes (2r+1)^2 ticks per
// center, set by the one brush offset the scan tests per tick. Reset puts
// the walk idle and the sizes at 256; an output stall holds the result and
// any tick waiting in the input register and backs up s_axis_tready. A start
// transaction never waits for the output.
module thick_line_rasterizer import tlr_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_start, y_start, x_end, y_end, brush_radius, pen_color, zero fill
  input  logic [((4*COORD_BITS+40+7)/8)*8-1:0]  s_axis_tdata,
  // command
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [55:0]                           m_axis_tdata,
  // pixel_valid
  output logic                                  m_axis_tuser,
  // line_done
  output logic                                  m_axis_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [APB_ADDR_BITS-1:0]              paddr,
  input  logic [APB_DATA_BITS-1:0]              pwdata,
  output logic [APB_DATA_BITS-1:0]              prdata,
  output logic                                  pready
);

  localparam int CB      = COORD_BITS;
  localparam int XS_LSB  = 0;
  localparam int YS_LSB  = CB;
  localparam int XE_LSB  = 2 * CB;
  localparam int YE_LSB  = 3 * CB;
  localparam int RAD_LSB = 4 * CB;
  localparam int COL_LSB = 4 * CB + RADIUS_BITS;

  // Clamp bound for a configured image size.
  function automatic logic [PIXEL_COORD_BITS-1:0] size_top(
    input logic [CFG_SIZE_BITS-1:0] size
  );
    logic [CFG_SIZE_BITS-1:0] m1;
    m1 = size - CFG_SIZE_BITS'(1);
    if (size == '0) begin
      return '0;
    end else if (size > CFG_SIZE_BITS'(OUT_COORD_MAX + 1)) begin
      return PIXEL_COORD_BITS'(OUT_COORD_MAX);
    end else begin
      return m1[PIXEL_COORD_BITS-1:0];
    end
  endfunction

  // Configuration registers.
  logic [CFG_SIZE_BITS-1:0] width_q, height_q;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? APB_DATA_BITS'(height_q)
                                                 : APB_DATA_BITS'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_SIZE_BITS'(256);
      height_q <= CFG_SIZE_BITS'(256);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        width_q <= pwdata[CFG_SIZE_BITS-1:0];
      end else begin
        height_q <= pwdata[CFG_SIZE_BITS-1:0];
      end
    end
  end

  // Unpack the input transaction and form the deltas ahead of the register.
  logic signed [CB-1:0]        xs_in, ys_in, xe_in, ye_in;
  logic signed [CB:0]          dx_in, dy_in;
  logic        [CB-1:0]        adx_in, ady_in;
  logic        [RADIUS_BITS-1:0] rad_in;
  logic        [RSQ_BITS-1:0]  rsq_in;

  always_comb begin
    xs_in  = $signed(s_axis_tdata[XS_LSB +: CB]);
    ys_in  = $signed(s_axis_tdata[YS_LSB +: CB]);
    xe_in  = $signed(s_axis_tdata[XE_LSB +: CB]);
    ye_in  = $signed(s_axis_tdata[YE_LSB +: CB]);
    rad_in = s_axis_tdata[RAD_LSB +: RADIUS_BITS];
    dx_in  = (CB+1)'(xe_in) - (CB+1)'(xs_in);
    dy_in  = (CB+1)'(ye_in) - (CB+1)'(ys_in);
    adx_in = dx_in[CB] ? CB'(-dx_in) : CB'(dx_in);
    ady_in = dy_in[CB] ? CB'(-dy_in) : CB'(dy_in);
    rsq_in = RSQ_BITS'(rad_in) * RSQ_BITS'(rad_in);
  end

  // Input register.
  logic                      in_valid_q;
  tlr_cmd_e                  in_cmd_q;
  logic signed [CB-1:0]      xa_q, ya_q, xb_q, yb_q;
  logic signed [CB:0]        dx_q, dy_q;
  logic        [CB-1:0]      adx_q, ady_q;
  logic [RADIUS_BITS-1:0]    rad_q;
  logic [RSQ_BITS-1:0]       rsq_q;
  logic [COLOR_BITS-1:0]     color_q;
  logic                      s_fire, advance;

  logic out_valid_q;
  tlr_result_t out_q;
  tlr_result_t result;

  // A start has no result and always moves on; a tick needs room at the output.
  assign advance       = in_valid_q && ((in_cmd_q == CMD_START) || !out_valid_q
                         || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cmd_q <= tlr_cmd_e'(s_axis_tuser);
      xa_q     <= xs_in;
      ya_q     <= ys_in;
      xb_q     <= xe_in;
      yb_q     <= ye_in;
      dx_q     <= dx_in;
      dy_q     <= dy_in;
      adx_q    <= adx_in;
      ady_q    <= ady_in;
      rad_q    <= rad_in;
      rsq_q    <= rsq_in;
      color_q  <= s_axis_tdata[COL_LSB +: COLOR_BITS];
    end
  end

  tlr_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (advance && (in_cmd_q == CMD_START)),
    .tick_i    (advance && (in_cmd_q == CMD_TICK)),
    .xa_i      (xa_q),
    .ya_i      (ya_q),
    .xb_i      (xb_q),
    .yb_i      (yb_q),
    .dx_i      (dx_q),
    .dy_i      (dy_q),
    .adx_i     (adx_q),
    .ady_i     (ady_q),
    .radius_i  (rad_q),
    .rsq_i     (rsq_q),
    .color_i   (color_q),
    .col_top_i (size_top(width_q)),
    .row_top_i (size_top(height_q)),
    .result_o  (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && (in_cmd_q == CMD_TICK)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (in_cmd_q == CMD_TICK)) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.color, out_q.y, out_q.x};
  assign m_axis_tuser  = out_q.valid;
  assign m_axis_tlast  = out_q.done;

endmodule

// ----- hw/rtl/tlr_checker.sv -----
// Port-level checks of the thick line rasterizer, bound to the top level.
// Depends on tlr_pkg and on the port list of thick_line_rasterizer.
module tlr_checker import tlr_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  // x_start, y_start, x_end, y_end, brush_radius, pen_color, zero fill
  input logic [((4*COORD_BITS+40+7)/8)*8-1:0]  s_axis_tdata,
  // command
  input logic                                  s_axis_tuser,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  // pixel_x, pixel_y, pixel_color
  input logic [55:0]                           m_axis_tdata,
  // pixel_valid
  input logic                                  m_axis_tuser,
  // line_done
  input logic                                  m_axis_tlast,
  input logic                                  psel,
  input logic                                  penable,
  input logic                                  pwrite,
  input logic [APB_ADDR_BITS-1:0]              paddr,
  input logic [APB_DATA_BITS-1:0]              pwdata,
  input logic [APB_DATA_BITS-1:0]              prdata,
  input logic                                  pready
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // An offered input transaction waits unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
      && $stable(s_axis_tuser))
    else $error("stalled input transaction changed");

  // A result without a pixel write carries no coordinates or color.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without write has nonzero payload");

  // A written size reads back on the following cycle.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=>
      (paddr[2] != $past(paddr[2]))
      || (prdata == APB_DATA_BITS'($past(pwdata[CFG_SIZE_BITS-1:0]))))
    else $error("register readback mismatch");

  // A fresh result follows an accepted tick transaction, by way of the input and output registers.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TICK), 2))
    else $error("result without an accepted tick");

endmodule

bind thick_line_rasterizer tlr_checker #(.COORD_BITS(COORD_BITS)) u_tlr_checker (.*);
